// ===== rtl/core/cubic_bezier_spline_edit_eval_core_defines.svh =====
// assertion helpers for the checker file
`ifndef CUBIC_BEZIER_SPLINE_EDIT_EVAL_CORE_DEFINES_SVH
`define CUBIC_BEZIER_SPLINE_EDIT_EVAL_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define CBSE_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cbse assertion failed");

// condition holds in every cycle out of reset
`define CBSE_ASSERT_ALWAYS(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
    else $error("cbse assertion failed");

`endif

// ===== rtl/core/cbse_pkg.sv =====
// ----------------------------------------------------------------------------
// cbse_pkg
// Shared types, constants and tables of the cubic Bezier spline core.
// ----------------------------------------------------------------------------
`default_nettype none

package cbse_pkg;

  localparam int unsigned NUM_SEG         = 3;
  localparam int unsigned NUM_PTS         = 4 * NUM_SEG;
  localparam int unsigned ADDR_W          = $clog2(NUM_PTS);
  localparam logic [3:0]  LAST_IDX        = 4'(3 * NUM_SEG);
  localparam int unsigned COORD_FRAC_BITS = 14;
  localparam logic signed [16:0] ONE_FX   = 17'(1 << COORD_FRAC_BITS);
  localparam int unsigned RES_W           = 10;
  localparam logic [RES_W-1:0] RES_RESET  = 10'd64;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_MOVE_ONE,
    OP_MOVE_JOINT,
    OP_SAMPLE
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [ADDR_W-1:0]  addr_a;
    logic [ADDR_W-1:0]  addr_b;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [RES_W-1:0]   step;
  } cmd_t;

  function automatic logic [2:0] div3(input logic [3:0] v);
    logic [2:0] q;
    case (v)
      4'd0, 4'd1, 4'd2:    q = 3'd0;
      4'd3, 4'd4, 4'd5:    q = 3'd1;
      4'd6, 4'd7, 4'd8:    q = 3'd2;
      4'd9, 4'd10, 4'd11:  q = 3'd3;
      4'd12, 4'd13, 4'd14: q = 3'd4;
      default:             q = 3'd5;
    endcase
    return q;
  endfunction

  // reset contents of the point store
  function automatic logic signed [15:0] init_x(input logic [ADDR_W-1:0] a);
    logic signed [15:0] x;
    case (a)
      4'd0:          x = -16'sd16384;
      4'd1:          x = -16'sd14418;
      4'd2:          x = -16'sd6881;
      4'd3, 4'd4:    x = -16'sd8192;
      4'd5:          x = -16'sd3277;
      4'd6:          x = 16'sd3277;
      4'd7, 4'd8:    x = 16'sd8192;
      4'd9:          x = 16'sd13107;
      default:       x = 16'sd16384;
    endcase
    return x;
  endfunction

  function automatic logic signed [15:0] init_y(input logic [ADDR_W-1:0] a);
    logic signed [15:0] y;
    case (a)
      4'd1:                          y = 16'sd5243;
      4'd2:                          y = 16'sd8028;
      4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
      4'd8:                          y = 16'sd8192;
      4'd9:                          y = 16'sd6554;
      4'd10:                         y = 16'sd3441;
      default:                       y = 16'sd0;
    endcase
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cbse_front.sv =====
// ----------------------------------------------------------------------------
// cbse_front
// Takes items, decodes them into commands and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cbse_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 func_i,
  input  logic [3:0]           point_index_i,
  input  logic signed [15:0]   delta_x_i,
  input  logic signed [15:0]   delta_y_i,
  input  logic [1:0]           sample_segment_i,
  input  logic [9:0]           step_i,
  input  logic                 pop_i,
  output logic                 cmd_valid_o,
  output cbse_pkg::cmd_t       cmd_o
);

  cbse_pkg::cmd_t cmd;
  cbse_pkg::cmd_t slot_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q;
  logic [2:0]     seg;
  logic [3:0]     rem;
  logic [3:0]     base;
  logic           push, pop;

  assign seg  = cbse_pkg::div3(point_index_i);
  assign rem  = point_index_i - 4'({1'b0, seg} * 4'd3);
  assign base = {seg[1:0], 2'b00};

  always_comb begin
    cmd.dx     = delta_x_i;
    cmd.dy     = delta_y_i;
    cmd.step   = step_i;
    cmd.op     = cbse_pkg::OP_NONE;
    cmd.addr_a = '0;
    cmd.addr_b = '0;
    if (func_i) begin
      if (sample_segment_i < 2'(cbse_pkg::NUM_SEG)) begin
        cmd.op     = cbse_pkg::OP_SAMPLE;
        cmd.addr_a = {sample_segment_i, 2'b00};
      end
    end else if (point_index_i == cbse_pkg::LAST_IDX) begin
      cmd.op     = cbse_pkg::OP_MOVE_ONE;
      cmd.addr_a = cbse_pkg::ADDR_W'(cbse_pkg::NUM_PTS - 1);
    end else if (point_index_i < cbse_pkg::LAST_IDX) begin
      if (point_index_i != 4'd0 && rem == 4'd0) begin
        // joint point: end of previous segment first, then start of this one
        cmd.op     = cbse_pkg::OP_MOVE_JOINT;
        cmd.addr_a = base - 4'd1;
        cmd.addr_b = base;
      end else begin
        cmd.op     = cbse_pkg::OP_MOVE_ONE;
        cmd.addr_a = base + rem;
      end
    end
  end

  assign busy_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign push        = start_i && !busy_o;
  assign pop         = pop_i && cmd_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= cmd;
  end

endmodule

`default_nettype wire

// ===== rtl/core/cbse_back.sv =====
// ----------------------------------------------------------------------------
// cbse_back
// Executes queued commands: point store, shared multiplier, serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module cbse_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  cbse_pkg::cmd_t                 cmd_i,
  output logic                           pop_o,
  input  logic [cbse_pkg::RES_W-1:0]     resolution_i,
  output logic                           done_o,
  output logic signed [15:0]             point_x_o,
  output logic signed [15:0]             point_y_o
);

  localparam int unsigned AW = cbse_pkg::ADDR_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MV1,
    ST_MV2,
    ST_SMP,
    ST_DIV_INIT,
    ST_DIV
  } state_e;

  state_e             state_q;
  cbse_pkg::cmd_t     cmd_q;
  logic [4:0]         sc_q;
  logic [3:0]         cnt_q;
  logic               done_q;
  logic signed [15:0] px_q, py_q;

  // point store
  logic [31:0]        mem_q [cbse_pkg::NUM_PTS];
  logic [cbse_pkg::NUM_PTS-1:0] valid_q;
  logic [31:0]        rd_q;
  logic               rd_en, wr_en;
  logic [AW-1:0]      rd_addr, wr_addr;
  logic [31:0]        wr_data;

  // arithmetic
  logic [9:0]          r_q, u_q, v_q;
  logic [19:0]         vv_q, uu_q, rr_q;
  logic [30:0]         w0_q, w1_q, w2_q, w3_q;
  logic [29:0]         den_q;
  logic signed [47:0]  prod_q, accx_q, accy_q;
  logic [30:0]         mul_a;
  logic signed [16:0]  mul_b;
  logic signed [48:0]  prod_full;
  logic signed [16:0]  pt_x, pt_y;
  logic [9:0]          r_in, u_in;

  // divider
  logic [31:0]         remx_q, remy_q;
  logic [15:0]         numx_q, numy_q, qx_q, qy_q;
  logic [15:0]         qx_d, qy_d;
  logic [31:0]         remx_d, remy_d;
  logic [32:0]         tx, ty;
  logic [30:0]         d2_q;
  logic                negx_q, negy_q;
  logic [47:0]         absx, absy, nx, ny;

  logic signed [15:0]  mv_x, mv_y;

  function automatic logic signed [15:0] clamp_c(input logic signed [15:0] p,
                                                 input logic signed [15:0] d,
                                                 input logic signed [16:0] lo);
    logic signed [16:0] s;
    logic signed [15:0] res;
    s = 17'(p) + 17'(d);
    if (s < lo)                    res = lo[15:0];
    else if (s > cbse_pkg::ONE_FX) res = cbse_pkg::ONE_FX[15:0];
    else                           res = s[15:0];
    return res;
  endfunction

  assign mv_x = clamp_c(rd_q[31:16], cmd_q.dx, -cbse_pkg::ONE_FX);
  assign mv_y = clamp_c(rd_q[15:0], cmd_q.dy, 17'sd0);

  assign pt_x = 17'($signed(rd_q[31:16]));
  assign pt_y = 17'($signed(rd_q[15:0]));

  assign r_in = (resolution_i == '0) ? 10'd1 : resolution_i;
  assign u_in = (cmd_i.step > r_in) ? r_in : cmd_i.step;

  assign pop_o = (state_q == ST_IDLE) && cmd_valid_i;

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cmd_q.addr_a;
    wr_en   = 1'b0;
    wr_addr = cmd_q.addr_a;
    wr_data = {mv_x, mv_y};
    case (state_q)
      ST_IDLE: begin
        rd_en   = pop_o;
        rd_addr = cmd_i.addr_a;
      end
      ST_MV1: begin
        wr_en   = 1'b1;
        rd_en   = (cmd_q.op == cbse_pkg::OP_MOVE_JOINT);
        rd_addr = cmd_q.addr_b;
      end
      ST_MV2: begin
        wr_en   = 1'b1;
        wr_addr = cmd_q.addr_b;
      end
      ST_SMP: begin
        rd_en   = (sc_q == 5'd6) || (sc_q == 5'd8) || (sc_q == 5'd10) || (sc_q == 5'd12);
        rd_addr = {cmd_q.addr_a[AW-1:2], 2'(sc_q[4:1] - 4'd3)};
      end
      default: begin
      end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (sc_q)
      5'd0:  begin mul_a = 31'(v_q);  mul_b = 17'(v_q); end
      5'd1:  begin mul_a = 31'(u_q);  mul_b = 17'(u_q); end
      5'd2:  begin mul_a = 31'(vv_q); mul_b = 17'(v_q); end
      5'd3:  begin mul_a = 31'(vv_q); mul_b = 17'(u_q); end
      5'd4:  begin mul_a = 31'(uu_q); mul_b = 17'(v_q); end
      5'd5:  begin mul_a = 31'(uu_q); mul_b = 17'(u_q); end
      5'd6:  begin mul_a = 31'(r_q);  mul_b = 17'(r_q); end
      5'd7:  begin mul_a = w0_q;      mul_b = pt_x; end
      5'd8:  begin mul_a = w0_q;      mul_b = pt_y; end
      5'd9:  begin mul_a = w1_q;      mul_b = pt_x; end
      5'd10: begin mul_a = w1_q;      mul_b = pt_y; end
      5'd11: begin mul_a = w2_q;      mul_b = pt_x; end
      5'd12: begin mul_a = w2_q;      mul_b = pt_y; end
      5'd13: begin mul_a = w3_q;      mul_b = pt_x; end
      5'd14: begin mul_a = w3_q;      mul_b = pt_y; end
      5'd15: begin mul_a = 31'(rr_q); mul_b = 17'(r_q); end
      default: begin
      end
    endcase
  end

  assign prod_full = $signed({1'b0, mul_a}) * mul_b;

  // one restoring step per cycle on each lane
  always_comb begin
    tx = {remx_q, numx_q[15]};
    ty = {remy_q, numy_q[15]};
    if (tx >= {2'b00, d2_q}) begin
      remx_d = 32'(tx - {2'b00, d2_q});
      qx_d   = {qx_q[14:0], 1'b1};
    end else begin
      remx_d = tx[31:0];
      qx_d   = {qx_q[14:0], 1'b0};
    end
    if (ty >= {2'b00, d2_q}) begin
      remy_d = 32'(ty - {2'b00, d2_q});
      qy_d   = {qy_q[14:0], 1'b1};
    end else begin
      remy_d = ty[31:0];
      qy_d   = {qy_q[14:0], 1'b0};
    end
  end

  assign absx = accx_q[47] ? 48'(-accx_q) : accx_q;
  assign absy = accy_q[47] ? 48'(-accy_q) : accy_q;
  assign nx   = {absx[46:0], 1'b0} + 48'(den_q);
  assign ny   = {absy[46:0], 1'b0} + 48'(den_q);

  // control and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sc_q    <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      px_q    <= '0;
      py_q    <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            sc_q <= '0;
            case (cmd_i.op)
              cbse_pkg::OP_MOVE_ONE,
              cbse_pkg::OP_MOVE_JOINT: state_q <= ST_MV1;
              cbse_pkg::OP_SAMPLE:     state_q <= ST_SMP;
              default: begin
                done_q <= 1'b1;
                px_q   <= '0;
                py_q   <= '0;
              end
            endcase
          end
        end
        ST_MV1: begin
          if (cmd_q.op == cbse_pkg::OP_MOVE_JOINT) begin
            state_q <= ST_MV2;
          end else begin
            done_q  <= 1'b1;
            px_q    <= mv_x;
            py_q    <= mv_y;
            state_q <= ST_IDLE;
          end
        end
        ST_MV2: begin
          done_q  <= 1'b1;
          px_q    <= mv_x;
          py_q    <= mv_y;
          state_q <= ST_IDLE;
        end
        ST_SMP: begin
          sc_q <= sc_q + 5'd1;
          if (sc_q == 5'd16) state_q <= ST_DIV_INIT;
        end
        ST_DIV_INIT: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            done_q  <= 1'b1;
            px_q    <= negx_q ? 16'(-qx_d) : qx_d;
            py_q    <= negy_q ? 16'(-qy_d) : qy_d;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q  <= cmd_i;
      r_q    <= r_in;
      u_q    <= u_in;
      v_q    <= r_in - u_in;
      accx_q <= '0;
      accy_q <= '0;
    end
    prod_q <= prod_full[47:0];
    if (state_q == ST_SMP) begin
      case (sc_q)
        5'd1:  vv_q <= prod_q[19:0];
        5'd2:  uu_q <= prod_q[19:0];
        5'd3:  w0_q <= prod_q[30:0];
        5'd4:  w1_q <= prod_q[30:0] + {prod_q[29:0], 1'b0};
        5'd5:  w2_q <= prod_q[30:0] + {prod_q[29:0], 1'b0};
        5'd6:  w3_q <= prod_q[30:0];
        5'd7:  rr_q <= prod_q[19:0];
        5'd8, 5'd10, 5'd12, 5'd14: accx_q <= accx_q + prod_q;
        5'd9, 5'd11, 5'd13, 5'd15: accy_q <= accy_q + prod_q;
        5'd16: den_q <= prod_q[29:0];
        default: begin
        end
      endcase
    end
    if (state_q == ST_DIV_INIT) begin
      d2_q   <= {den_q, 1'b0};
      remx_q <= nx[47:16];
      remy_q <= ny[47:16];
      numx_q <= nx[15:0];
      numy_q <= ny[15:0];
      qx_q   <= '0;
      qy_q   <= '0;
      negx_q <= accx_q[47];
      negy_q <= accy_q[47];
    end
    if (state_q == ST_DIV) begin
      remx_q <= remx_d;
      remy_q <= remy_d;
      qx_q   <= qx_d;
      qy_q   <= qy_d;
      numx_q <= {numx_q[14:0], 1'b0};
      numy_q <= {numy_q[14:0], 1'b0};
    end
  end

  // point store: entries read as their reset value until first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_q <= valid_q[rd_addr] ? mem_q[rd_addr]
                               : {cbse_pkg::init_x(rd_addr), cbse_pkg::init_y(rd_addr)};
    end
  end

  assign done_o    = done_q;
  assign point_x_o = px_q;
  assign point_y_o = py_q;

endmodule

`default_nettype wire

// ===== rtl/core/cubic_bezier_spline_edit_eval_core.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_spline_edit_eval_core
// Editable cubic Bezier spline: moves control points and samples the curve.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+------------------------------------
//  command   | start_i / busy_o          | func, point_index, delta_x/y,
//            |                           | sample_segment, step
//  result    | done_o (one-cycle strobe) | point_x_o, point_y_o
//  config    | cfg_valid_i / cfg_ready_o | cfg_data_i (resolution)
//
//  a two-entry command queue sits in front; busy_o is high only when it is full
//  a move passes through ST_MV1 in the back end (and ST_MV2 for a joint point),
//  an out-of-range item is answered straight from ST_IDLE
//  a sample runs a command fetch, the products on the shared 32x17 multiplier,
//  one divider set-up and 16 steps of the restoring divider
//  reset clears the queue, the store valid bits and resolution (64)
//  results are not held: done_o marks each one for exactly one cycle
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_spline_edit_eval_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic                 func_i,
  input  logic [3:0]           point_index_i,
  input  logic signed [15:0]   delta_x_i,
  input  logic signed [15:0]   delta_y_i,
  input  logic [1:0]           sample_segment_i,
  input  logic [9:0]           step_i,
  output logic                 done_o,
  output logic signed [15:0]   point_x_o,
  output logic signed [15:0]   point_y_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [9:0]           cfg_data_i
);

  cbse_pkg::cmd_t              cmd;
  logic                        cmd_valid, pop;
  logic [cbse_pkg::RES_W-1:0]  res_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= cbse_pkg::RES_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      res_q <= cfg_data_i;
    end
  end

  cbse_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .func_i           (func_i),
    .point_index_i    (point_index_i),
    .delta_x_i        (delta_x_i),
    .delta_y_i        (delta_y_i),
    .sample_segment_i (sample_segment_i),
    .step_i           (step_i),
    .pop_i            (pop),
    .cmd_valid_o      (cmd_valid),
    .cmd_o            (cmd)
  );

  cbse_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (cmd),
    .pop_o        (pop),
    .resolution_i (res_q),
    .done_o       (done_o),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/cbse_checker.sv =====
// ----------------------------------------------------------------------------
// cbse_checker
// Port-level checks on the spline core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cubic_bezier_spline_edit_eval_core_defines.svh"

module cbse_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input logic signed [15:0] point_x_o,
  input logic signed [15:0] point_y_o
);

  // every result lies in the clamp box
  `CBSE_ASSERT_IMPLY(a_x_range, clk_i, rst_ni, done_o, (point_x_o >= -16'sd16384) && (point_x_o <= 16'sd16384))
  `CBSE_ASSERT_IMPLY(a_y_range, clk_i, rst_ni, done_o, (point_y_o >= 16'sd0) && (point_y_o <= 16'sd16384))
  // the queue only fills through a transfer
  `CBSE_ASSERT_IMPLY(a_busy_rise, clk_i, rst_ni, $rose(busy_o), $past(start_i))

endmodule

bind cubic_bezier_spline_edit_eval_core cbse_checker u_cbse_checker (.*);

`default_nettype wire

// ===== tb/tb_cubic_bezier_spline_edit_eval_core.sv =====
// ----------------------------------------------------------------------------
// tb_cubic_bezier_spline_edit_eval_core
// Self-checking bench for the spline core: a directed table of moves and
// samples, then random traffic under several resolutions, with every result
// compared against a typed expectation or a local model of the store and sampler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_cubic_bezier_spline_edit_eval_core;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 40;

  typedef struct {
    logic               func;
    logic [3:0]         idx;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic [1:0]         seg;
    logic [9:0]         step;
    bit                 typed;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
  } row_t;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } point_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               func_i = 1'b0;
  logic [3:0]         point_index_i = '0;
  logic signed [15:0] delta_x_i = '0;
  logic signed [15:0] delta_y_i = '0;
  logic [1:0]         sample_segment_i = '0;
  logic [9:0]         step_i = '0;
  logic               done_o;
  logic signed [15:0] point_x_o;
  logic signed [15:0] point_y_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [9:0]         cfg_data_i = '0;

  // typed expectation for the item now on the command ports
  bit                 typed_v = 1'b0;
  point_t             typed_pt;

  longint             store_x [cbse_pkg::NUM_PTS];
  longint             store_y [cbse_pkg::NUM_PTS];
  logic [9:0]         resolution;
  point_t             pending_pts[$];
  int unsigned        mismatches = 0;
  int unsigned        results_seen = 0;
  int unsigned        samples_seen = 0;
  int unsigned        cycles = 0;
  int unsigned        idle_pct = 0;

  cubic_bezier_spline_edit_eval_core DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .point_index_i, .delta_x_i,
    .delta_y_i, .sample_segment_i, .step_i, .done_o, .point_x_o, .point_y_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint round_div(input longint num, input longint den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((2 * (-num) + den) / (2 * den));
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void shift_point(input int k, input longint dx, input longint dy);
    store_x[k] = clamp(store_x[k] + dx, -longint'(cbse_pkg::ONE_FX),
                       longint'(cbse_pkg::ONE_FX));
    store_y[k] = clamp(store_y[k] + dy, 0, longint'(cbse_pkg::ONE_FX));
  endfunction

  function automatic void reset_store();
    longint hx[cbse_pkg::NUM_PTS] = '{-100, -88, -42, -50, -50, -20, 20, 50, 50, 80, 100, 100};
    longint hy[cbse_pkg::NUM_PTS] = '{0, 32, 49, 50, 50, 50, 50, 50, 50, 40, 21, 0};
    for (int k = 0; k < cbse_pkg::NUM_PTS; k++) begin
      store_x[k] = round_div(hx[k] * longint'(cbse_pkg::ONE_FX), 100);
      store_y[k] = round_div(hy[k] * longint'(cbse_pkg::ONE_FX), 100);
    end
    resolution = cbse_pkg::RES_RESET;
  endfunction

  // updates the store for a move and returns the point the block reports
  function automatic point_t spline_item(input logic func, input logic [3:0] idx,
                                         input logic signed [15:0] dx,
                                         input logic signed [15:0] dy,
                                         input logic [1:0] seg, input logic [9:0] step);
    longint r, u, v, w0, w1, w2, w3, den, rx, ry;
    int     b, k, s;
    point_t p;
    rx = 0;
    ry = 0;
    k = -1;
    if (func) begin
      if (seg < cbse_pkg::NUM_SEG) begin
        r = (resolution == 0) ? 1 : resolution;
        u = (step > r) ? r : step;
        v = r - u;
        w0 = v * v * v;
        w1 = 3 * v * v * u;
        w2 = 3 * v * u * u;
        w3 = u * u * u;
        den = r * r * r;
        b = 4 * seg;
        rx = round_div(w0 * store_x[b] + w1 * store_x[b+1] + w2 * store_x[b+2]
                       + w3 * store_x[b+3], den);
        ry = round_div(w0 * store_y[b] + w1 * store_y[b+1] + w2 * store_y[b+2]
                       + w3 * store_y[b+3], den);
      end
    end else begin
      s = idx / 3;
      if (idx == cbse_pkg::LAST_IDX) begin
        k = cbse_pkg::NUM_PTS - 1;
        shift_point(k, dx, dy);
      end else if (idx < cbse_pkg::LAST_IDX && idx != 0 && idx % 3 == 0) begin
        // joint point: end of one segment and start of the next
        shift_point(4 * (s - 1) + 3, dx, dy);
        k = 4 * s;
        shift_point(k, dx, dy);
      end else if (idx < cbse_pkg::LAST_IDX) begin
        k = 4 * s + (idx - 3 * s);
        shift_point(k, dx, dy);
      end
      if (k >= 0) begin
        rx = store_x[k];
        ry = store_y[k];
      end
    end
    p.x = rx[15:0];
    p.y = ry[15:0];
    return p;
  endfunction

  always @(posedge clk_i) begin
    point_t p;
    point_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) resolution = cfg_data_i;
      if (done_o) begin
        results_seen++;
        if (pending_pts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result x=%0d y=%0d", point_x_o, point_y_o);
        end else begin
          e = pending_pts.pop_front();
          if (e.x !== point_x_o || e.y !== point_y_o) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected x=%0d y=%0d, got x=%0d y=%0d",
                       e.x, e.y, point_x_o, point_y_o);
          end
        end
      end
      if (start_i && !busy_o) begin
        p = spline_item(func_i, point_index_i, delta_x_i, delta_y_i, sample_segment_i,
                        step_i);
        if (func_i) samples_seen++;
        if (typed_v) p = typed_pt;
        pending_pts.insert(pending_pts.size(), p);
      end
    end
  end

  // drives one command and holds it until the transfer
  task automatic send_item(input row_t it);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(6, 1);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i          <= 1'b1;
    func_i           <= it.func;
    point_index_i    <= it.idx;
    delta_x_i        <= it.dx;
    delta_y_i        <= it.dy;
    sample_segment_i <= it.seg;
    step_i           <= it.step;
    typed_v          <= it.typed;
    typed_pt.x       <= it.ex;
    typed_pt.y       <= it.ey;
    // busy_o only moves at the rising edge, so it shows the coming edge here
    while (busy_o) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_pts.size() != 0) @(negedge clk_i);
    repeat (DRAIN_WAIT) @(negedge clk_i);
  endtask

  task automatic write_resolution(input logic [9:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    while (!cfg_ready_o) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic row_t random_item();
    row_t it;
    it.typed = 1'b0;
    it.ex = '0;
    it.ey = '0;
    it.func = 1'($urandom_range(1));
    it.idx = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
    if ($urandom_range(3) == 0) begin
      it.dx = 16'($urandom);
      it.dy = 16'($urandom);
    end else begin
      it.dx = 16'($urandom_range(4000)) - 16'sd2000;
      it.dy = 16'($urandom_range(4000)) - 16'sd2000;
    end
    it.seg = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
    it.step = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(resolution));
    return it;
  endfunction

  initial begin
    row_t        directed[$];
    logic [9:0]  res_plan[6];
    reset_store();
    directed = '{
      '{1, 0, 0, 0, 0, 0, 1, -16384, 0},
      '{1, 0, 0, 0, 2, 1023, 1, 16384, 0},
      '{1, 0, 0, 0, 3, 5, 1, 0, 0},
      '{0, 15, 32767, 32767, 0, 0, 1, 0, 0},
      '{0, 10, -5, 5, 0, 0, 1, 0, 0},
      '{1, 0, 0, 0, 1, 32, 0, 0, 0},
      '{0, 1, 32767, 32767, 0, 0, 1, 16384, 16384},
      '{0, 2, -32768, -32768, 0, 0, 1, -16384, 0},
      '{0, 0, 0, 0, 0, 0, 1, -16384, 0},
      '{0, 3, 100, -100, 0, 0, 0, 0, 0},
      '{0, 6, -32768, 32767, 0, 0, 1, -16384, 16384},
      '{0, 9, 32767, -32768, 0, 0, 1, 16384, 0},
      '{0, 4, 1234, -777, 0, 0, 0, 0, 0},
      '{0, 5, -3000, 2500, 0, 0, 0, 0, 0},
      '{0, 7, 20, 30, 0, 0, 0, 0, 0},
      '{0, 8, -40, 60, 0, 0, 0, 0, 0},
      '{1, 0, 0, 0, 0, 17, 0, 0, 0},
      '{1, 0, 0, 0, 1, 63, 0, 0, 0},
      '{1, 0, 0, 0, 2, 1, 0, 0, 0},
      '{1, 0, 0, 0, 1, 64, 0, 0, 0}
    };
    res_plan = '{10'd1, 10'd1023, 10'd0, 10'd64, 10'($urandom_range(1023, 2)), 10'd5};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) send_item(directed[i]);
    typed_v <= 1'b0;
    for (int ph = 0; ph < 6; ph++) begin
      write_resolution(res_plan[ph]);
      idle_pct = (ph < 2) ? 29 : (ph < 4) ? 50 : 0;
      for (int n = 0; n < 272; n++) send_item(random_item());
    end
    drain();
    $display("%0d results checked, %0d of them curve samples, over six resolutions",
             results_seen, samples_seen);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/cbse_pkg.sv
rtl/core/cbse_front.sv
rtl/core/cbse_back.sv
rtl/core/cubic_bezier_spline_edit_eval_core.sv
rtl/core/cbse_checker.sv
tb/tb_cubic_bezier_spline_edit_eval_core.sv
